// File: rtl/lmhp_pkg.sv
`timescale 1ns / 1ps

package lmhp_pkg;

	// Defaults for the top-level parameters.
	localparam int DEF_MAX_OPTIONS     = 15;
	localparam int DEF_JOIN_LENGTH     = 23;
	localparam int DEF_MIN_DATA_LENGTH = 12;

	// Depth of the queue between the byte parser and the record emitter.
	localparam int QUEUE_DEPTH = 2;

	// Message types that are kept.
	localparam logic [2:0] MTYPE_JOIN_REQ   = 3'b000;
	localparam logic [2:0] MTYPE_UNCONF_UP  = 3'b010;
	localparam logic [2:0] MTYPE_CONF_UP    = 3'b100;

	// Byte offsets inside the frame.
	localparam logic [7:0] POS_HEADER    = 8'd0;
	localparam logic [7:0] POS_ADDR_LAST = 8'd4;
	localparam logic [7:0] POS_CTRL      = 8'd5;
	localparam logic [7:0] POS_FCNT_LO   = 8'd6;
	localparam logic [7:0] POS_FCNT_HI   = 8'd7;
	localparam logic [7:0] POS_OPT_BASE  = 8'd8;
	localparam logic [7:0] POS_MAX       = 8'd255;

	localparam logic [7:0] OPT_LEN_MASK = 8'b00001111;

	// Per-packet header carried from the parser to the emitter.
	typedef struct packed {
		logic [2:0]  mtype;
		logic [31:0] addr;
		logic [7:0]  ctrl;
		logic [15:0] fcnt;
		logic [7:0]  port;
		logic [7:0]  rssi;
		logic [7:0]  snr;
		logic [3:0]  runs;
	} lmhp_hdr_t;

endpackage

// File: rtl/lmhp_queue.sv
`timescale 1ns / 1ps

module lmhp_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             empty
);
	import lmhp_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// The queue is never overrun or underrun by its neighbors.
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue pushed while full");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("queue popped while empty");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue fill count did not follow a lone push");

endmodule

// File: rtl/lmhp_front.sv
`timescale 1ns / 1ps

module lmhp_front #(
	parameter int MAX_OPTIONS     = lmhp_pkg::DEF_MAX_OPTIONS,
	parameter int JOIN_LENGTH     = lmhp_pkg::DEF_JOIN_LENGTH,
	parameter int MIN_DATA_LENGTH = lmhp_pkg::DEF_MIN_DATA_LENGTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   byte_acc,
	input  logic [7:0]             packet_byte,
	input  logic                   last_byte,
	input  logic [7:0]             signal_strength,
	input  logic [7:0]             noise_ratio,
	output logic                   push,
	output lmhp_pkg::lmhp_hdr_t    push_hdr,
	output logic [8*MAX_OPTIONS-1:0] push_opts
);
	import lmhp_pkg::*;

	localparam int IDX_W = (MAX_OPTIONS > 1) ? $clog2(MAX_OPTIONS) : 1;

	logic [7:0]  pos_q;
	logic [7:0]  header_q, header_d;
	logic [31:0] addr_q, addr_d;
	logic [7:0]  ctrl_q, ctrl_d;
	logic [15:0] fcnt_q, fcnt_d;
	logic [7:0]  port_q, port_d;
	logic [7:0]  store_q [MAX_OPTIONS];

	logic [7:0]       opt_k;
	logic [3:0]       count_d;
	logic             opt_wr;
	logic [IDX_W-1:0] opt_idx;
	logic [2:0]       mtype;
	logic             keep;
	logic [3:0]       runs;

	// Field capture for the byte at the current position.
	always_comb begin
		header_d = header_q;
		addr_d   = addr_q;
		ctrl_d   = ctrl_q;
		fcnt_d   = fcnt_q;
		port_d   = port_q;
		opt_k    = pos_q - POS_OPT_BASE;
		opt_wr   = 1'b0;
		opt_idx  = opt_k[IDX_W-1:0];
		if (pos_q == POS_HEADER) begin
			header_d = packet_byte;
		end else if (pos_q <= POS_ADDR_LAST) begin
			addr_d = {addr_q[23:0], packet_byte};
		end else if (pos_q == POS_CTRL) begin
			ctrl_d = packet_byte;
		end else if (pos_q == POS_FCNT_LO) begin
			fcnt_d = {fcnt_q[15:8], packet_byte};
		end else if (pos_q == POS_FCNT_HI) begin
			fcnt_d = {packet_byte, fcnt_q[7:0]};
		end else begin
			opt_wr = (opt_k < {4'd0, ctrl_q[3:0]}) && (opt_k < 8'(MAX_OPTIONS));
			if (opt_k == {4'd0, ctrl_q[3:0]}) begin
				port_d = packet_byte;
			end
		end
	end

	assign count_d = ctrl_d[3:0] & OPT_LEN_MASK[3:0];
	assign mtype   = header_d[7:5];

	// Packet length is pos_q + 1, so each length test is written on pos_q.
	always_comb begin
		case (mtype)
			MTYPE_JOIN_REQ:  keep = ({1'b0, pos_q} + 9'd1 == 9'(JOIN_LENGTH));
			MTYPE_UNCONF_UP: keep = ({1'b0, pos_q} + 9'd1 >= 9'(MIN_DATA_LENGTH));
			MTYPE_CONF_UP:   keep = ({1'b0, pos_q} + 9'd1 >= 9'(MIN_DATA_LENGTH));
			default:         keep = 1'b0;
		endcase
	end

	always_comb begin
		if (count_d == 4'd0) begin
			runs = 4'd1;
		end else if (count_d > 4'(MAX_OPTIONS)) begin
			runs = 4'(MAX_OPTIONS);
		end else begin
			runs = count_d;
		end
	end

	// Option bytes that were not inside this packet read as zero.
	always_comb begin
		for (int k = 0; k < MAX_OPTIONS; k++) begin
			if ((4'(k) < count_d) && ({1'b0, POS_OPT_BASE} + 9'(k) <= {1'b0, pos_q})) begin
				if (opt_wr && (opt_idx == IDX_W'(k))) begin
					push_opts[8*k +: 8] = packet_byte;
				end else begin
					push_opts[8*k +: 8] = store_q[k];
				end
			end else begin
				push_opts[8*k +: 8] = 8'd0;
			end
		end
	end

	always_comb begin
		push_hdr.mtype = mtype;
		push_hdr.addr  = addr_d;
		push_hdr.ctrl  = ctrl_d;
		push_hdr.fcnt  = fcnt_d;
		push_hdr.port  = ({1'b0, POS_OPT_BASE} + {5'd0, count_d} <= {1'b0, pos_q}) ?
			port_d : 8'd0;
		push_hdr.rssi  = signal_strength;
		push_hdr.snr   = noise_ratio;
		push_hdr.runs  = runs;
	end

	assign push = byte_acc && last_byte && keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			header_q <= '0;
			addr_q   <= '0;
			ctrl_q   <= '0;
			fcnt_q   <= '0;
			port_q   <= '0;
		end else if (byte_acc) begin
			header_q <= header_d;
			addr_q   <= addr_d;
			ctrl_q   <= ctrl_d;
			fcnt_q   <= fcnt_d;
			port_q   <= port_d;
			if (last_byte) begin
				pos_q <= '0;
			end else if (pos_q != POS_MAX) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_acc && opt_wr) begin
			store_q[opt_idx] <= packet_byte;
		end
	end

endmodule

// File: rtl/lmhp_back.sv
`timescale 1ns / 1ps

module lmhp_back #(
	parameter int MAX_OPTIONS = lmhp_pkg::DEF_MAX_OPTIONS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_empty,
	input  lmhp_pkg::lmhp_hdr_t      q_hdr,
	input  logic [8*MAX_OPTIONS-1:0] q_opts,
	output logic                     q_pop,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [2:0]               message_type,
	output logic [31:0]              device_address,
	output logic                     adaptive_rate,
	output logic                     rate_ack_request,
	output logic                     acknowledge,
	output logic [15:0]              frame_counter,
	output logic [3:0]               option_count,
	output logic [7:0]               port_number,
	output logic [7:0]               packet_rssi,
	output logic signed [7:0]        packet_snr,
	output logic [7:0]               option_byte,
	output logic                     last_of_run
);
	import lmhp_pkg::*;

	logic                     busy_q;
	logic [3:0]               remaining_q;
	lmhp_hdr_t                hdr_q;
	logic [8*MAX_OPTIONS-1:0] opts_q;
	logic                     out_acc;
	logic                     done;

	assign out_acc = busy_q && !out_stall;
	assign done    = out_acc && (remaining_q == 4'd1);
	assign q_pop   = !q_empty && (!busy_q || done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			remaining_q <= '0;
		end else if (q_pop) begin
			busy_q      <= 1'b1;
			remaining_q <= q_hdr.runs;
		end else if (done) begin
			busy_q      <= 1'b0;
			remaining_q <= '0;
		end else if (out_acc) begin
			remaining_q <= remaining_q - 1'b1;
		end
	end

	// The option bytes shift down one record at a time.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			hdr_q  <= q_hdr;
			opts_q <= q_opts;
		end else if (out_acc) begin
			opts_q <= opts_q >> 8;
		end
	end

	assign out_valid        = busy_q;
	assign message_type     = hdr_q.mtype;
	assign device_address   = hdr_q.addr;
	assign adaptive_rate    = hdr_q.ctrl[7];
	assign rate_ack_request = hdr_q.ctrl[6];
	assign acknowledge      = hdr_q.ctrl[5];
	assign frame_counter    = hdr_q.fcnt;
	assign option_count     = hdr_q.ctrl[3:0];
	assign port_number      = hdr_q.port;
	assign packet_rssi      = hdr_q.rssi;
	assign packet_snr       = hdr_q.snr;
	assign option_byte      = opts_q[7:0];
	assign last_of_run      = (remaining_q == 4'd1);

	assert property (@(posedge clk) disable iff (!arst_n) busy_q |-> (remaining_q != 4'd0))
		else $error("emitter busy with no records left");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && !done) |=> (busy_q && (remaining_q == $past(remaining_q) - 1'b1)))
		else $error("record count did not step down after a transaction");
	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (remaining_q >= 4'd1 && remaining_q <= 4'(MAX_OPTIONS)))
		else $error("loaded run length out of range");

endmodule

// File: rtl/lorawan_mac_header_parser_core.sv
`timescale 1ns / 1ps

// LoRaWAN uplink MAC header parser. Packet bytes enter one per transaction,
// the first being the MAC header, with the final byte marked by last_byte
// and carrying the packet's RSSI and SNR. The input side accepts a byte in
// every cycle while the two-entry packet queue has room; only when two
// parsed packets are already waiting behind the record currently on the
// output does in_stall rise. A join request of exactly JOIN_LENGTH bytes or
// a confirmed or unconfirmed data uplink of at least MIN_DATA_LENGTH bytes
// yields a run of max(1, FOptsLen) records, capped at MAX_OPTIONS. With the
// emitter idle, the first record is offered once the packet has been
// written into the queue and then loaded into the emitter, and the
// records then leave one per cycle while out_stall is low; each record
// repeats the header fields and carries one option byte, with last_of_run
// on the final one. Other packets produce nothing. The record emitter, at
// one record per cycle while out_stall is low, sets the output rate.
module lorawan_mac_header_parser_core #(
	parameter int MAX_OPTIONS     = lmhp_pkg::DEF_MAX_OPTIONS,
	parameter int JOIN_LENGTH     = lmhp_pkg::DEF_JOIN_LENGTH,
	parameter int MIN_DATA_LENGTH = lmhp_pkg::DEF_MIN_DATA_LENGTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        packet_byte,
	input  logic              last_byte,
	input  logic [7:0]        signal_strength,
	input  logic signed [7:0] noise_ratio,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        message_type,
	output logic [31:0]       device_address,
	output logic              adaptive_rate,
	output logic              rate_ack_request,
	output logic              acknowledge,
	output logic [15:0]       frame_counter,
	output logic [3:0]        option_count,
	output logic [7:0]        port_number,
	output logic [7:0]        packet_rssi,
	output logic signed [7:0] packet_snr,
	output logic [7:0]        option_byte,
	output logic              last_of_run
);
	import lmhp_pkg::*;

	localparam int Q_WIDTH = $bits(lmhp_hdr_t) + 8 * MAX_OPTIONS;

	logic                     byte_acc;
	logic                     push;
	lmhp_hdr_t                push_hdr;
	logic [8*MAX_OPTIONS-1:0] push_opts;
	logic                     q_pop;
	logic [Q_WIDTH-1:0]       q_data;
	logic                     q_full;
	logic                     q_empty;
	lmhp_hdr_t                q_hdr;
	logic [8*MAX_OPTIONS-1:0] q_opts;

	// The parser stalls whenever the queue cannot take a finished packet.
	assign in_stall = q_full;
	assign byte_acc = in_valid && !in_stall;

	lmhp_front #(
		.MAX_OPTIONS    (MAX_OPTIONS),
		.JOIN_LENGTH    (JOIN_LENGTH),
		.MIN_DATA_LENGTH(MIN_DATA_LENGTH)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.byte_acc       (byte_acc),
		.packet_byte    (packet_byte),
		.last_byte      (last_byte),
		.signal_strength(signal_strength),
		.noise_ratio    (noise_ratio),
		.push           (push),
		.push_hdr       (push_hdr),
		.push_opts      (push_opts)
	);

	lmhp_queue #(
		.WIDTH(Q_WIDTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({push_hdr, push_opts}),
		.pop      (q_pop),
		.pop_data (q_data),
		.full     (q_full),
		.empty    (q_empty)
	);

	assign q_hdr  = q_data[Q_WIDTH-1 -: $bits(lmhp_hdr_t)];
	assign q_opts = q_data[8*MAX_OPTIONS-1:0];

	lmhp_back #(
		.MAX_OPTIONS(MAX_OPTIONS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_empty         (q_empty),
		.q_hdr           (q_hdr),
		.q_opts          (q_opts),
		.q_pop           (q_pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.message_type    (message_type),
		.device_address  (device_address),
		.adaptive_rate   (adaptive_rate),
		.rate_ack_request(rate_ack_request),
		.acknowledge     (acknowledge),
		.frame_counter   (frame_counter),
		.option_count    (option_count),
		.port_number     (port_number),
		.packet_rssi     (packet_rssi),
		.packet_snr      (packet_snr),
		.option_byte     (option_byte),
		.last_of_run     (last_of_run)
	);

endmodule

// File: sim/lorawan_mac_header_parser_core_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the uplink MAC header parser.
//
// Packets are pushed into the block one byte per transaction. A behavioral
// copy of the parser below watches every accepted byte and, when the last
// byte of a kept packet is accepted, queues the run of option records the
// block must produce. The output monitor pops that queue on every accepted
// record and compares all twelve fields.
//
// The stimulus starts with a short table of hand-built packets covering the
// length limits, every message type, the option-count cap, absent port and
// option bytes and field extremes. A few rows also carry the run length or
// port value that can be read off directly. Random packets follow: the
// first few are kept ones sent while the receiver holds off, the rest are
// mostly well-formed joins and data uplinks with random content, plus
// truncated packets and pure noise.
module lorawan_mac_header_parser_core_tb;

	import lmhp_pkg::*;

	localparam int MAX_OPTS         = DEF_MAX_OPTIONS;
	localparam int NOT_TYPED        = -1;
	localparam int RANDOM_PACKETS   = 6;
	localparam int PRESSURE_PACKETS = 4;
	localparam int HOLD_CYCLES      = 300;
	localparam int IDLE_LIMIT       = 3000;
	localparam int TAIL_CYCLES      = 20;
	localparam int REPORT_LIMIT     = 10;
	localparam int DIRECTED_ROWS    = 18;

	// One output record of the block.
	typedef struct packed {
		logic [2:0]  mtype;
		logic [31:0] addr;
		logic        adr;
		logic        adr_ack_req;
		logic        ack;
		logic [15:0] fcnt;
		logic [3:0]  opt_count;
		logic [7:0]  port;
		logic [7:0]  rssi;
		logic [7:0]  snr;
		logic [7:0]  opt;
		logic        run_end;
	} uplink_record_t;

	// Description of one packet to send. The two *_known fields hold a
	// value that is obvious from the packet itself, or NOT_TYPED.
	typedef struct packed {
		logic [7:0]  header;
		int          len;
		logic [7:0]  ctrl;
		logic [31:0] addr;
		logic [15:0] fcnt;
		logic [7:0]  rssi;
		logic [7:0]  snr;
		int          runs_known;
		int          port_known;
	} packet_spec_t;

	// Output stall behavior, picked per segment by the receiver.
	typedef enum logic [1:0] {
		FLOW_FREE,
		FLOW_CHOPPY,
		FLOW_HEAVY
	} flow_mode_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [7:0]        packet_byte;
	logic              last_byte;
	logic [7:0]        signal_strength;
	logic signed [7:0] noise_ratio;
	logic              out_valid;
	logic              out_stall;
	logic [2:0]        message_type;
	logic [31:0]       device_address;
	logic              adaptive_rate;
	logic              rate_ack_request;
	logic              acknowledge;
	logic [15:0]       frame_counter;
	logic [3:0]        option_count;
	logic [7:0]        port_number;
	logic [7:0]        packet_rssi;
	logic signed [7:0] packet_snr;
	logic [7:0]        option_byte;
	logic              last_of_run;

	lorawan_mac_header_parser_core dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.packet_byte      (packet_byte),
		.last_byte        (last_byte),
		.signal_strength  (signal_strength),
		.noise_ratio      (noise_ratio),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.message_type     (message_type),
		.device_address   (device_address),
		.adaptive_rate    (adaptive_rate),
		.rate_ack_request (rate_ack_request),
		.acknowledge      (acknowledge),
		.frame_counter    (frame_counter),
		.option_count     (option_count),
		.port_number      (port_number),
		.packet_rssi      (packet_rssi),
		.packet_snr       (packet_snr),
		.option_byte      (option_byte),
		.last_of_run      (last_of_run)
	);

	// 12 ns clock.
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// ------------------------------------------------------------------
	// Parser shadow state. It mirrors what the block keeps between bytes.
	// ------------------------------------------------------------------
	logic [7:0]  shadow_pos;
	logic [7:0]  shadow_header;
	logic [31:0] shadow_addr;
	logic [7:0]  shadow_ctrl;
	logic [15:0] shadow_fcnt;
	logic [7:0]  shadow_opts [MAX_OPTS];
	logic [7:0]  shadow_port;

	// Records still owed by the block, oldest first.
	uplink_record_t pending_records [$];

	// Bookkeeping filled in by the parser shadow on each final byte.
	int predicted_runs;
	int predicted_port;

	int  failures;
	int  idle_cycles;
	int  burst_left;
	bit  hold_request;
	int  hold_left;

	packet_spec_t directed_rows [DIRECTED_ROWS];

	function automatic string show_record(input uplink_record_t r);
		return $sformatf({"type=%0d addr=%h adr=%b ackreq=%b ack=%b fcnt=%h fopts=%0d ",
			"port=%h rssi=%h snr=%h opt=%h last=%b"}, r.mtype, r.addr, r.adr,
			r.adr_ack_req, r.ack, r.fcnt, r.opt_count, r.port, r.rssi, r.snr, r.opt,
			r.run_end);
	endfunction

	// Every failure goes through here; only the first few are spelled out.
	task automatic count_failure(input string msg);
		if (failures < REPORT_LIMIT)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		failures++;
	endtask

	// Feeds one accepted byte into the shadow parser. When the byte closes a
	// kept packet, the whole record run is appended to pending_records.
	task automatic parse_uplink_byte(input logic [7:0] value, input logic final_byte,
			input logic [7:0] rssi, input logic [7:0] snr);
		logic [8:0]     frame_len;
		logic [3:0]     fopts;
		logic [2:0]     mtype;
		logic [7:0]     port_val;
		logic [7:0]     opt_val;
		logic           keep;
		int             slot;
		int             runs;
		int             k;
		uplink_record_t rec;

		fopts = shadow_ctrl[3:0];
		if (shadow_pos == POS_HEADER) begin
			shadow_header = value;
		end else if (shadow_pos <= POS_ADDR_LAST) begin
			shadow_addr = {shadow_addr[23:0], value};
		end else if (shadow_pos == POS_CTRL) begin
			shadow_ctrl = value;
		end else if (shadow_pos == POS_FCNT_LO) begin
			shadow_fcnt[7:0] = value;
		end else if (shadow_pos == POS_FCNT_HI) begin
			shadow_fcnt[15:8] = value;
		end else begin
			// Option bytes first, then FPort right behind them. Options past
			// the storage depth are dropped but still shift the port.
			slot = shadow_pos - POS_OPT_BASE;
			if (slot < fopts && slot < MAX_OPTS)
				shadow_opts[slot] = value;
			if (slot == fopts)
				shadow_port = value;
		end

		if (!final_byte) begin
			// The position sticks at its maximum on very long packets.
			if (shadow_pos != POS_MAX)
				shadow_pos = shadow_pos + 8'd1;
		end else begin
			frame_len = {1'b0, shadow_pos} + 9'd1;
			shadow_pos = POS_HEADER;
			mtype = shadow_header[7:5];
			if (mtype == MTYPE_JOIN_REQ)
				keep = (frame_len == DEF_JOIN_LENGTH);
			else if (mtype == MTYPE_UNCONF_UP || mtype == MTYPE_CONF_UP)
				keep = (frame_len >= DEF_MIN_DATA_LENGTH);
			else
				keep = 1'b0;

			predicted_runs = 0;
			predicted_port = 0;
			if (keep) begin
				fopts = shadow_ctrl[3:0];
				port_val = (POS_OPT_BASE + fopts < frame_len) ? shadow_port : 8'd0;
				runs = (fopts == 4'd0) ? 1 : fopts;
				if (runs > MAX_OPTS)
					runs = MAX_OPTS;
				predicted_runs = runs;
				predicted_port = port_val;
				for (k = 0; k < runs; k++) begin
					opt_val = 8'd0;
					if (k < fopts && k < MAX_OPTS && POS_OPT_BASE + k < frame_len)
						opt_val = shadow_opts[k];
					rec.mtype       = mtype;
					rec.addr        = shadow_addr;
					rec.adr         = shadow_ctrl[7];
					rec.adr_ack_req = shadow_ctrl[6];
					rec.ack         = shadow_ctrl[5];
					rec.fcnt        = shadow_fcnt;
					rec.opt_count   = fopts;
					rec.port        = port_val;
					rec.rssi        = rssi;
					rec.snr         = snr;
					rec.opt         = opt_val;
					rec.run_end     = (k + 1 == runs);
					pending_records.push_back(rec);
				end
			end
		end
	endtask

	// Offers one byte and returns at the edge where it was taken. The sender
	// runs in bursts; between bursts in_valid may drop for a random gap.
	task automatic send_byte(input logic [7:0] value, input logic final_byte,
			input logic [7:0] rssi, input logic [7:0] snr);
		int gap;

		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
				: $urandom_range(1, 24);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;

		in_valid        <= 1'b1;
		packet_byte     <= value;
		last_byte       <= final_byte;
		signal_strength <= rssi;
		noise_ratio     <= snr;
		do
			@(posedge clk);
		while (in_stall);
		parse_uplink_byte(value, final_byte, rssi, snr);
	endtask

	// Sends a whole packet. Header fields come from the spec; the rest is
	// either random or a fixed pattern so the directed rows are repeatable.
	// RSSI and SNR only matter on the final byte, so earlier bytes carry junk.
	task automatic send_packet(input packet_spec_t spec, input bit random_body);
		logic [7:0] value;
		int         idx;

		for (idx = 0; idx < spec.len; idx++) begin
			if (idx == POS_HEADER)
				value = spec.header;
			else if (idx <= POS_ADDR_LAST)
				value = spec.addr[8 * (POS_ADDR_LAST - idx) +: 8];
			else if (idx == POS_CTRL)
				value = spec.ctrl;
			else if (idx == POS_FCNT_LO)
				value = spec.fcnt[7:0];
			else if (idx == POS_FCNT_HI)
				value = spec.fcnt[15:8];
			else
				value = random_body ? 8'($urandom) : 8'((idx * 29) ^ 8'hA5);
			if (idx == spec.len - 1)
				send_byte(value, 1'b1, spec.rssi, spec.snr);
			else
				send_byte(value, 1'b0, 8'($urandom), 8'($urandom));
		end
	endtask

	// Builds and sends one random packet. Most are kept by the block; the
	// rest are truncated or off-length packets and random noise. With
	// kept_only set, only packets the block keeps are built.
	task automatic send_random_packet(input bit kept_only);
		packet_spec_t spec;
		int           pick;

		pick = kept_only ? $urandom_range(0, 7) : $urandom_range(0, 9);
		spec.addr       = $urandom;
		spec.ctrl       = 8'($urandom);
		spec.fcnt       = 16'($urandom);
		spec.rssi       = 8'($urandom);
		spec.snr        = 8'($urandom);
		spec.runs_known = NOT_TYPED;
		spec.port_known = NOT_TYPED;
		if (pick < 2) begin
			spec.header = {MTYPE_JOIN_REQ, 5'($urandom)};
			spec.len    = DEF_JOIN_LENGTH;
		end else if (pick < 8) begin
			spec.header = {(($urandom_range(0, 1) == 1) ? MTYPE_CONF_UP : MTYPE_UNCONF_UP),
				5'($urandom)};
			spec.len = DEF_MIN_DATA_LENGTH + $urandom_range(0, 20);
		end else if (pick == 8) begin
			// A kept type, but a length the block must refuse.
			if ($urandom_range(0, 1) == 1) begin
				spec.header = {MTYPE_JOIN_REQ, 5'($urandom)};
				spec.len    = ($urandom_range(0, 1) == 1) ? DEF_JOIN_LENGTH - 1
					: DEF_JOIN_LENGTH + 1;
			end else begin
				spec.header = {MTYPE_UNCONF_UP, 5'($urandom)};
				spec.len    = $urandom_range(1, DEF_MIN_DATA_LENGTH - 1);
			end
		end else begin
			spec.header = 8'($urandom);
			spec.len    = $urandom_range(1, 30);
		end
		send_packet(spec, 1'b1);
	endtask

	// Lowers in_valid and waits for every owed record to come out.
	task automatic drain_outputs;
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_records.size() != 0);
	endtask

	// ------------------------------------------------------------------
	// Receiver: random segments of free flow, light and heavy stalling, and
	// a long hold-off on request so the block backs up into its input.
	// ------------------------------------------------------------------
	initial begin
		flow_mode_t mode;
		int         segment_left;

		segment_left = 0;
		mode = FLOW_FREE;
		hold_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (segment_left == 0) begin
					mode = flow_mode_t'($urandom_range(0, 2));
					segment_left = $urandom_range(1, 40);
				end
				segment_left--;
				case (mode)
					FLOW_FREE: begin
						out_stall <= 1'b0;
					end
					FLOW_CHOPPY: begin
						out_stall <= ($urandom_range(0, 1) == 1);
					end
					default: begin
						out_stall <= ($urandom_range(0, 3) != 0);
					end
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Output monitor. Each record taken from the block is checked against
	// the oldest owed record.
	// ------------------------------------------------------------------
	uplink_record_t seen_record;
	uplink_record_t owed_record;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen_record.mtype       = message_type;
			seen_record.addr        = device_address;
			seen_record.adr         = adaptive_rate;
			seen_record.adr_ack_req = rate_ack_request;
			seen_record.ack         = acknowledge;
			seen_record.fcnt        = frame_counter;
			seen_record.opt_count   = option_count;
			seen_record.port        = port_number;
			seen_record.rssi        = packet_rssi;
			seen_record.snr         = packet_snr;
			seen_record.opt         = option_byte;
			seen_record.run_end     = last_of_run;
			if (pending_records.size() == 0) begin
				count_failure({"record with nothing owed: ", show_record(seen_record)});
			end else begin
				owed_record = pending_records.pop_front();
				if (seen_record !== owed_record)
					count_failure({"expected ", show_record(owed_record), " got ",
						show_record(seen_record)});
			end
		end
	end

	// Watchdog: too long without any transaction on either side means the
	// block has hung.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[%0t] watchdog expired, %0d records owed", $realtime,
				pending_records.size());
			$display("** lorawan_mac_header_parser_core: FAILED **");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------
	initial begin
		int row;
		int packets_sent;

		arst_n          <= 1'b0;
		in_valid        <= 1'b0;
		packet_byte     <= 8'd0;
		last_byte       <= 1'b0;
		signal_strength <= 8'd0;
		noise_ratio     <= 8'sd0;

		failures = 0;
		idle_cycles = 0;
		burst_left = 0;
		hold_request = 1'b0;
		predicted_runs = 0;
		predicted_port = 0;
		shadow_pos = POS_HEADER;
		shadow_header = 8'd0;
		shadow_addr = 32'd0;
		shadow_ctrl = 8'd0;
		shadow_fcnt = 16'd0;
		shadow_port = 8'd0;
		for (row = 0; row < MAX_OPTS; row++)
			shadow_opts[row] = 8'd0;

		// Directed packets: header, length, frame control, address, frame
		// counter, RSSI, SNR, then the run length and port where obvious.
		// Join request at exactly the required length, then one short and
		// one long.
		directed_rows[0]  = '{8'h00, 23, 8'h00, 32'hA1B2C3D4, 16'h1234, 8'h40, 8'h05,
			1, NOT_TYPED};
		directed_rows[1]  = '{8'h00, 22, 8'h00, 32'h0, 16'h0, 8'h00, 8'h00, 0, NOT_TYPED};
		directed_rows[2]  = '{8'h00, 24, 8'h00, 32'h0, 16'h0, 8'h00, 8'h00, 0, NOT_TYPED};
		// Shortest kept data uplink with all-ones fields, then one byte too short.
		directed_rows[3]  = '{8'h40, 12, 8'h00, 32'hFFFFFFFF, 16'hFFFF, 8'hFF, 8'h80,
			1, NOT_TYPED};
		directed_rows[4]  = '{8'h40, 11, 8'h00, 32'h0, 16'h0, 8'h00, 8'h00, 0, NOT_TYPED};
		// All-zero fields with every flag bit set and three options.
		directed_rows[5]  = '{8'h80, 12, 8'hE3, 32'h00000000, 16'h0000, 8'h00, 8'h7F,
			3, NOT_TYPED};
		// Full option field with the port byte just inside the packet.
		directed_rows[6]  = '{8'h9F, 24, 8'h0F, 32'h12345678, 16'h00FF, 8'h9A, 8'hC3,
			15, NOT_TYPED};
		// Same, but the packet ends right before the port byte.
		directed_rows[7]  = '{8'h80, 23, 8'h0F, 32'h00FF00FF, 16'hFF00, 8'h11, 8'hEE, 15, 0};
		// Options running past the end of the packet read as zero.
		directed_rows[8]  = '{8'h40, 12, 8'h05, 32'h80000001, 16'h8001, 8'h01, 8'hFE, 5, 0};
		directed_rows[9]  = '{8'h5F, 12, 8'h1F, 32'h01020304, 16'h0102, 8'h7F, 8'h01, 15, 0};
		// Every message type the block must refuse.
		directed_rows[10] = '{8'h20, 12, 8'h00, 32'h0, 16'h0, 8'h00, 8'h00, 0, NOT_TYPED};
		directed_rows[11] = '{8'h60, 12, 8'h00, 32'h0, 16'h0, 8'h00, 8'h00, 0, NOT_TYPED};
		directed_rows[12] = '{8'hA0, 12, 8'h00, 32'h0, 16'h0, 8'h00, 8'h00, 0, NOT_TYPED};
		directed_rows[13] = '{8'hC0, 12, 8'h00, 32'h0, 16'h0, 8'h00, 8'h00, 0, NOT_TYPED};
		directed_rows[14] = '{8'hFF, 23, 8'h00, 32'h0, 16'h0, 8'h00, 8'h00, 0, NOT_TYPED};
		// Single byte packet.
		directed_rows[15] = '{8'h40, 1, 8'h00, 32'h0, 16'h0, 8'h00, 8'h00, 0, NOT_TYPED};
		// Join request whose frame control nibble is all ones.
		directed_rows[16] = '{8'h00, 23, 8'hFF, 32'h0BADF00D, 16'h7FFF, 8'h80, 8'h81, 15, 0};
		// Port byte is the final byte of the packet.
		directed_rows[17] = '{8'h40, 12, 8'h03, 32'hCAFE0001, 16'h0001, 8'hFE, 8'hFF,
			3, NOT_TYPED};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (row = 0; row < DIRECTED_ROWS; row++) begin
			send_packet(directed_rows[row], 1'b0);
			if (directed_rows[row].runs_known != NOT_TYPED &&
					directed_rows[row].runs_known != predicted_runs)
				count_failure($sformatf("directed row %0d: run length %0d, expected %0d",
					row, predicted_runs, directed_rows[row].runs_known));
			if (directed_rows[row].port_known != NOT_TYPED &&
					directed_rows[row].port_known != predicted_port)
				count_failure($sformatf("directed row %0d: port %0d, expected %0d",
					row, predicted_port, directed_rows[row].port_known));
		end

		// Let the block run dry before the random phase.
		drain_outputs();

		// The receiver now holds off for a long stretch while kept packets
		// keep coming, so the packet queue fills and the input stalls.
		hold_request = 1'b1;
		for (packets_sent = 0; packets_sent < RANDOM_PACKETS; packets_sent++) begin
			send_random_packet(packets_sent < PRESSURE_PACKETS);
			// One pause after the pressure packets with the sender fully quiet.
			if (packets_sent == PRESSURE_PACKETS - 1)
				drain_outputs();
		end

		drain_outputs();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (failures == 0 && pending_records.size() == 0) begin
			$display("** lorawan_mac_header_parser_core: PASSED **");
		end else begin
			$display("** lorawan_mac_header_parser_core: FAILED **");
		end
		$finish;
	end

endmodule
